>>> rtl/pfrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrm_pkg
// Shared types and constants of the range rule matcher: table size, request
// codes and the transaction record that walks down the row of rule cells.
// ----------------------------------------------------------------------------
package pfrm_pkg;

	localparam int MAX_RULES = 64;

	localparam int CLASS_W = 9;
	localparam int PORT_W  = 16;
	localparam int ADDR_W  = 32;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CHECK = 1'b1
	} op_t;

	// transaction as it travels through the cells
	// done: add already placed in a cell, or check already matched a rule
	typedef struct packed {
		logic               vld;
		op_t                op;
		logic               done;
		logic [CLASS_W-1:0] cls;
		logic [PORT_W-1:0]  port_lo;
		logic [PORT_W-1:0]  port_hi;
		logic [ADDR_W-1:0]  addr_lo;
		logic [ADDR_W-1:0]  addr_hi;
	} item_t;

endpackage

>>> rtl/pfrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrm_if
// Valid/ready channels of the range rule matcher: request and response.
// ----------------------------------------------------------------------------
interface pfrm_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic        direction;
	logic [7:0]  protocol;
	logic [15:0] port_low;
	logic [15:0] port_high;
	logic [31:0] addr_low;
	logic [31:0] addr_high;

	modport source (
		output valid, op, direction, protocol, port_low, port_high, addr_low, addr_high,
		input  ready
	);
	modport sink (
		input  valid, op, direction, protocol, port_low, port_high, addr_low, addr_high,
		output ready
	);
endinterface

interface pfrm_rsp_if;
	logic valid;
	logic ready;
	logic allow;
	logic table_full;

	modport source (
		output valid, allow, table_full,
		input  ready
	);
	modport sink (
		input  valid, allow, table_full,
		output ready
	);
endinterface

>>> rtl/pfrm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrm_cell
// One rule slot. Holds a rule once an add reaches it while empty, matches
// passing checks against it and hands the transaction on to the next cell.
// ----------------------------------------------------------------------------
module pfrm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  pfrm_pkg::item_t item_in,
	output pfrm_pkg::item_t item_out
);

	logic                         occ_q;
	logic [pfrm_pkg::CLASS_W-1:0] cls_q;
	logic [pfrm_pkg::PORT_W-1:0]  port_lo_q;
	logic [pfrm_pkg::PORT_W-1:0]  port_hi_q;
	logic [pfrm_pkg::ADDR_W-1:0]  addr_lo_q;
	logic [pfrm_pkg::ADDR_W-1:0]  addr_hi_q;
	pfrm_pkg::item_t              item_q;

	logic            capture;
	logic            hit;
	pfrm_pkg::item_t item_nxt;

	always_comb begin
		capture = item_in.vld && (item_in.op == pfrm_pkg::OP_ADD) && !item_in.done && !occ_q;
		hit     = item_in.vld && (item_in.op == pfrm_pkg::OP_CHECK) && occ_q
		          && (item_in.cls == cls_q)
		          && (item_in.port_lo >= port_lo_q) && (item_in.port_lo <= port_hi_q)
		          && (item_in.addr_lo >= addr_lo_q) && (item_in.addr_lo <= addr_hi_q);
		item_nxt      = item_in;
		item_nxt.done = item_in.done || capture || hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			item_q <= '0;
		end else if (adv) begin
			item_q <= item_nxt;
			if (capture) begin
				occ_q <= 1'b1;
			end
		end
	end

	// rule contents, no reset
	always_ff @(posedge clk) begin
		if (adv && capture) begin
			cls_q     <= item_in.cls;
			port_lo_q <= item_in.port_lo;
			port_hi_q <= item_in.port_hi;
			addr_lo_q <= item_in.addr_lo;
			addr_hi_q <= item_in.addr_hi;
		end
	end

	assign item_out = item_q;

endmodule

>>> rtl/packet_filter_range_rule_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_filter_range_rule_match
// Packet filter rule table: a row of rule cells that stores appended rules
// in order and allows a packet when a stored rule covers it.
//
//   channel | dir | payload
//   --------+-----+--------------------------------------------------------
//   req     | in  | op, direction, protocol, port_low/high, addr_low/high
//   rsp     | out | allow, table_full
//
// Each transaction walks the row of MAX_RULES cells (64), one cell a cycle
// while the row advances, and a new request is taken every cycle while the
// response side keeps up. The last cell's register is the response
// register. Backpressure on rsp freezes the whole row and drops req.ready.
// Reset empties the table and the row at once.
// ----------------------------------------------------------------------------
module packet_filter_range_rule_match (
	input logic          clk,
	input logic          arst_n,
	pfrm_req_if.sink     req,
	pfrm_rsp_if.source   rsp
);

	pfrm_pkg::item_t chain [pfrm_pkg::MAX_RULES+1];
	pfrm_pkg::item_t last;
	logic            adv;

	assign last = chain[pfrm_pkg::MAX_RULES];
	// the row moves unless a finished response is being held
	assign adv  = !last.vld || rsp.ready;

	always_comb begin
		chain[0].vld     = req.valid;
		chain[0].op      = pfrm_pkg::op_t'(req.op);
		chain[0].done    = 1'b0;
		chain[0].cls     = {req.direction, req.protocol};
		chain[0].port_lo = req.port_low;
		chain[0].port_hi = req.port_high;
		chain[0].addr_lo = req.addr_low;
		chain[0].addr_hi = req.addr_high;
	end

	for (genvar i = 0; i < pfrm_pkg::MAX_RULES; i++) begin : g_cell
		pfrm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.item_in  (chain[i]),
			.item_out (chain[i+1])
		);
	end

	assign req.ready      = adv;
	assign rsp.valid      = last.vld;
	assign rsp.allow      = (last.op == pfrm_pkg::OP_CHECK) && last.done;
	assign rsp.table_full = (last.op == pfrm_pkg::OP_ADD) && !last.done;

endmodule

>>> rtl/pfrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrm_checker
// Port-level checks of the range rule matcher, bound to the top level.
// ----------------------------------------------------------------------------
module pfrm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_op,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic allow,
	input logic table_full
);

	localparam int CNT_W = $clog2(pfrm_pkg::MAX_RULES + 2);
	localparam logic [CNT_W-1:0] ADD_SAT = CNT_W'(pfrm_pkg::MAX_RULES + 1);

	logic             req_fire;
	logic             rsp_fire;
	logic [CNT_W-1:0] adds_q;
	logic [CNT_W-1:0] pend_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adds_q <= '0;
			pend_q <= '0;
		end else begin
			if (req_fire && (req_op == pfrm_pkg::OP_ADD) && (adds_q != ADD_SAT)) begin
				adds_q <= adds_q + CNT_W'(1);
			end
			if (req_fire && !rsp_fire) begin
				pend_q <= pend_q + CNT_W'(1);
			end else if (!req_fire && rsp_fire) begin
				pend_q <= pend_q - CNT_W'(1);
			end
		end
	end

	// a held response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(allow && table_full))
		else $error("allow and table_full together");

	// a full table needs more adds than slots
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full |-> adds_q == ADD_SAT)
		else $error("table_full before the table can be full");

	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != '0)
		else $error("response without an outstanding request");

endmodule

bind packet_filter_range_rule_match pfrm_checker u_pfrm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_op     (req.op),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.allow      (rsp.allow),
	.table_full (rsp.table_full)
);
